/* hdl/assert_macros.svh */
// Assertion macros shared by the clipped rectangle fill RTL.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is asserted.
`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, switched off while reset is asserted.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

/* hdl/cfr_pkg.sv */
// Package for the clipped rectangle fill block: sizes, codes, state and
// control types, and the colour mask function. Depends on nothing.
`timescale 1ns / 1ps

package cfr_pkg;

    // Framebuffer geometry and pixel storage width.
    localparam int MAX_WIDTH   = 128;
    localparam int MAX_HEIGHT  = 128;
    localparam int PIXEL_BITS  = 32;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    // Field widths.
    localparam int DIM_W      = 8;
    localparam int BPP_W      = 3;
    localparam int COORD_W    = 16;
    localparam int COLOR_W    = 32;
    localparam int COUNT_W    = 15;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // Register values after reset.
    localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(128);
    localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(128);
    localparam logic [BPP_W-1:0] BPP_RESET    = BPP_W'(3);

    typedef enum logic [0:0] {
        CMD_FILL = 1'b0,
        CMD_READ = 1'b1
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1,
        REG_PIXEL_BYTES  = 2'd2
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SETUP,
        ST_PREP,
        ST_FILL,
        ST_READ,
        ST_FINISH
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_step;
        logic load_item;
        logic setup;
        logic prep;
        logic fill_step;
        logic read_mem;
        logic load_out;
    } cfr_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;
        logic is_read;
        logic fill_go;
        logic read_bad;
        logic fill_last;
    } cfr_status_t;

    // Keeps as many low colour bytes as the pixel size register gives, with
    // zero taken as one byte and anything above four as four, and never more
    // than the stored bits.
    function automatic logic [PIXEL_BITS-1:0] color_mask(input logic [BPP_W-1:0] bpp);
        int bytes;
        int bits;
        logic [PIXEL_BITS-1:0] mask;
        bytes = int'(bpp);
        if (bytes == 0)
        begin
            bytes = 1;
        end
        if (bytes > 4)
        begin
            bytes = 4;
        end
        bits = bytes * 8;
        if (bits > PIXEL_BITS)
        begin
            bits = PIXEL_BITS;
        end
        for (int b = 0; b < PIXEL_BITS; b++)
        begin
            mask[b] = (b < bits);
        end
        return mask;
    endfunction

endpackage

/* hdl/cfr_if.sv */
// Channel interfaces of the clipped rectangle fill block: request,
// response and configuration write. Depends on cfr_pkg.
`timescale 1ns / 1ps

interface cfr_req_if import cfr_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               command;
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] fill_width;
    logic [COORD_W-1:0] fill_height;
    logic [COLOR_W-1:0] color;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;

    modport source (
        output valid, command, left, top, fill_width, fill_height, color, pixel_x, pixel_y,
        input  ready
    );
    modport sink (
        input  valid, command, left, top, fill_width, fill_height, color, pixel_x, pixel_y,
        output ready
    );
endinterface

interface cfr_rsp_if import cfr_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COLOR_W-1:0] pixel_value;
    logic [COUNT_W-1:0] pixels_written;
    logic               out_of_range;

    modport source (
        output valid, pixel_value, pixels_written, out_of_range,
        input  ready
    );
    modport sink (
        input  valid, pixel_value, pixels_written, out_of_range,
        output ready
    );
endinterface

interface cfr_cfg_if import cfr_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

/* hdl/cfr_datapath.sv */
// Datapath of the clipped rectangle fill block: configuration registers,
// clipping, fill address walk, frame store and result registers. Depends on cfr_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cfr_datapath import cfr_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  command,
    input  logic [COORD_W-1:0]    left,
    input  logic [COORD_W-1:0]    top,
    input  logic [COORD_W-1:0]    fill_width,
    input  logic [COORD_W-1:0]    fill_height,
    input  logic [COLOR_W-1:0]    color,
    input  logic [COORD_W-1:0]    pixel_x,
    input  logic [COORD_W-1:0]    pixel_y,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  cfr_cmd_t              cmd,
    output cfr_status_t           status,
    output logic [COLOR_W-1:0]    pixel_value,
    output logic [COUNT_W-1:0]    pixels_written,
    output logic                  out_of_range
);

    // Configuration registers.
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic [BPP_W-1:0] bpp_reg;

    // Request registers.
    cmd_t                cmd_reg;
    logic [COORD_W-1:0]  left_reg;
    logic [COORD_W-1:0]  top_reg;
    logic [COORD_W-1:0]  fw_reg;
    logic [COORD_W-1:0]  fh_reg;
    logic [COORD_W-1:0]  px_reg;
    logic [COORD_W-1:0]  py_reg;
    logic [PIXEL_BITS-1:0] color_reg;

    // Clipped span and read address.
    logic [DIM_W-1:0]  x_lo_reg;
    logic [DIM_W-1:0]  x_hi_reg;
    logic [DIM_W-1:0]  y_lo_reg;
    logic [DIM_W-1:0]  y_hi_reg;
    logic              go_reg;
    logic              bad_reg;
    logic [ADDR_W-1:0] rd_addr_reg;

    // Fill walk.
    logic [DIM_W-1:0]   x_reg;
    logic [DIM_W-1:0]   y_reg;
    logic [ADDR_W-1:0]  row_base_reg;
    logic [COUNT_W-1:0] area_reg;
    logic [ADDR_W-1:0]  clr_addr_reg;

    // Frame store.
    logic [PIXEL_BITS-1:0] mem [STORE_DEPTH];
    logic [PIXEL_BITS-1:0] rd_data_reg;

    // Result registers.
    logic [COLOR_W-1:0] pixel_value_reg;
    logic [COUNT_W-1:0] pixels_written_reg;
    logic               out_of_range_reg;

    logic [DIM_W-1:0]     w_eff;
    logic [DIM_W-1:0]     h_eff;
    logic [COORD_W:0]     right_sum;
    logic [COORD_W:0]     bottom_sum;
    logic [DIM_W-1:0]     x_hi_c;
    logic [DIM_W-1:0]     y_hi_c;
    logic                 go_c;
    logic                 bad_c;
    logic [2*DIM_W-1:0]   rd_prod;
    logic [ADDR_W-1:0]    rd_addr_c;
    logic [DIM_W-1:0]     dx_c;
    logic [DIM_W-1:0]     dy_c;
    logic [2*DIM_W-1:0]   area_prod;
    logic [2*DIM_W-1:0]   base_prod;
    logic [DIM_W-1:0]     x_inc;
    logic [DIM_W-1:0]     y_inc;
    logic                 x_last;
    logic                 y_last;
    logic [ADDR_W-1:0]    fill_addr;
    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_waddr;
    logic [PIXEL_BITS-1:0] mem_wdata;
    logic                 is_read;

    // Geometry above the store size is taken as the store size.
    assign w_eff = (32'(width_reg) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : width_reg;
    assign h_eff = (32'(height_reg) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : height_reg;

    assign is_read = (cmd_reg == CMD_READ);

    // Clipping; the sums carry one extra bit so they cannot wrap.
    assign right_sum  = {1'b0, left_reg} + {1'b0, fw_reg};
    assign bottom_sum = {1'b0, top_reg} + {1'b0, fh_reg};
    assign x_hi_c = (right_sum > (COORD_W+1)'(w_eff)) ? w_eff : right_sum[DIM_W-1:0];
    assign y_hi_c = (bottom_sum > (COORD_W+1)'(h_eff)) ? h_eff : bottom_sum[DIM_W-1:0];
    assign go_c = (left_reg <= COORD_W'(w_eff)) && (top_reg <= COORD_W'(h_eff))
                  && (left_reg[DIM_W-1:0] < x_hi_c) && (top_reg[DIM_W-1:0] < y_hi_c);

    assign bad_c     = (px_reg >= COORD_W'(w_eff)) || (py_reg >= COORD_W'(h_eff));
    assign rd_prod   = py_reg[DIM_W-1:0] * w_eff;
    assign rd_addr_c = ADDR_W'(rd_prod) + ADDR_W'(px_reg[DIM_W-1:0]);

    assign dx_c      = x_hi_reg - x_lo_reg;
    assign dy_c      = y_hi_reg - y_lo_reg;
    assign area_prod = dx_c * dy_c;
    assign base_prod = y_lo_reg * w_eff;

    assign x_inc     = x_reg + DIM_W'(1);
    assign y_inc     = y_reg + DIM_W'(1);
    assign x_last    = (x_inc == x_hi_reg);
    assign y_last    = (y_inc == y_hi_reg);
    assign fill_addr = row_base_reg + ADDR_W'(x_reg);

    assign mem_we    = cmd.clear_step || cmd.fill_step;
    assign mem_waddr = cmd.clear_step ? clr_addr_reg : fill_addr;
    assign mem_wdata = cmd.clear_step ? '0 : color_reg;

    assign status.clear_last = (clr_addr_reg == ADDR_W'(STORE_DEPTH - 1));
    assign status.is_read    = is_read;
    assign status.fill_go    = go_reg;
    assign status.read_bad   = bad_reg;
    assign status.fill_last  = x_last && y_last;

    assign pixel_value    = pixel_value_reg;
    assign pixels_written = pixels_written_reg;
    assign out_of_range   = out_of_range_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            bpp_reg    <= BPP_RESET;
        end
        else if (cfg_write)
        begin
            if (cfg_index == REG_IMAGE_WIDTH)
            begin
                width_reg <= cfg_data[DIM_W-1:0];
            end
            if (cfg_index == REG_IMAGE_HEIGHT)
            begin
                height_reg <= cfg_data[DIM_W-1:0];
            end
            if (cfg_index == REG_PIXEL_BYTES)
            begin
                bpp_reg <= cfg_data[BPP_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.clear_step)
        begin
            clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            cmd_reg   <= cmd_t'(command);
            left_reg  <= left;
            top_reg   <= top;
            fw_reg    <= fill_width;
            fh_reg    <= fill_height;
            px_reg    <= pixel_x;
            py_reg    <= pixel_y;
            color_reg <= color[PIXEL_BITS-1:0] & color_mask(bpp_reg);
        end
        if (cmd.setup)
        begin
            x_lo_reg    <= left_reg[DIM_W-1:0];
            x_hi_reg    <= x_hi_c;
            y_lo_reg    <= top_reg[DIM_W-1:0];
            y_hi_reg    <= y_hi_c;
            go_reg      <= go_c;
            bad_reg     <= bad_c;
            rd_addr_reg <= rd_addr_c;
        end
        if (cmd.prep)
        begin
            x_reg        <= x_lo_reg;
            y_reg        <= y_lo_reg;
            row_base_reg <= ADDR_W'(base_prod);
            area_reg     <= go_reg ? COUNT_W'(area_prod) : '0;
        end
        else if (cmd.fill_step)
        begin
            if (x_last)
            begin
                x_reg        <= x_lo_reg;
                y_reg        <= y_inc;
                row_base_reg <= row_base_reg + ADDR_W'(w_eff);
            end
            else
            begin
                x_reg <= x_inc;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.read_mem)
        begin
            rd_data_reg <= mem[rd_addr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_value_reg    <= '0;
            pixels_written_reg <= '0;
            out_of_range_reg   <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            pixel_value_reg    <= (is_read && !bad_reg) ? COLOR_W'(rd_data_reg) : '0;
            pixels_written_reg <= is_read ? '0 : area_reg;
            out_of_range_reg   <= is_read && bad_reg;
        end
    end

    // The fill walk never leaves the clipped span.
    `ASSERT_IMPLIES(a_fill_in_span, cmd.fill_step, (x_reg < x_hi_reg) && (y_reg < y_hi_reg))
    // A flagged read reports neither data nor a pixel count.
    `ASSERT_IMPLIES(a_bad_read_empty, out_of_range_reg,
                    (pixel_value_reg == '0) && (pixels_written_reg == '0))

endmodule

/* hdl/cfr_ctrl.sv */
// Controller of the clipped rectangle fill block: sequences the clearing
// pass, clipping, fill walk, pixel read and result hand-off. Depends on cfr_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cfr_ctrl import cfr_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    input  cfr_status_t status,
    output cfr_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;
    logic   out_free;

    // The result register can take a new result once its current one leaves.
    assign out_free = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                state_next = ST_PREP;
            end
            ST_PREP:
            begin
                priority if (status.is_read && !status.read_bad)
                begin
                    state_next = ST_READ;
                end
                else if (!status.is_read && status.fill_go)
                begin
                    state_next = ST_FILL;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FILL:
            begin
                if (status.fill_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_READ:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        req_ready = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
            end
            ST_IDLE:
            begin
                req_ready     = 1'b1;
                cmd.load_item = req_valid;
            end
            ST_SETUP:
            begin
                cmd.setup = 1'b1;
            end
            ST_PREP:
            begin
                cmd.prep = 1'b1;
            end
            ST_FILL:
            begin
                cmd.fill_step = 1'b1;
            end
            ST_READ:
            begin
                cmd.read_mem = 1'b1;
            end
            ST_FINISH:
            begin
                cmd.load_out = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // No request is taken before the clearing pass has finished.
    `ASSERT_IMPLIES(a_no_req_in_clear, state_reg == ST_CLEAR, !req_ready)
    // A new result only appears out of the finishing step.
    `ASSERT_IMPLIES(a_rsp_from_finish, $rose(rsp_valid_reg), $past(state_reg == ST_FINISH))
    // The last fill pixel always leads to the finishing step.
    `ASSERT_NEXT(a_fill_ends, (state_reg == ST_FILL) && status.fill_last,
                 state_reg == ST_FINISH)

endmodule

/* hdl/clipped_rectangle_fill.sv */
// Clipped rectangle fill: a framebuffer of MAX_WIDTH x MAX_HEIGHT pixels
// with a solid-fill engine. Depends on cfr_pkg, cfr_if, cfr_ctrl and cfr_datapath.
`timescale 1ns / 1ps

// After reset the block clears the whole frame store to zero, one pixel a
// cycle, and takes no request until that pass is over; configuration writes
// are taken throughout. A request is then handled one at a time by a
// controller and a datapath that share a single-port write, single-port read
// frame store. A read of a pixel inside the image passes from acceptance
// through clipping with address set-up, a preparation step, a registered
// memory read and the hand-off to the response register, and the next
// request is taken back in idle; a read outside the image skips the memory
// read. A fill writes the pixels it covers one after another, since the
// store accepts one write per cycle; a fill that is clipped away entirely
// skips the fill walk. The response sits in an output register, so the next
// request is accepted while the previous response still waits to be taken;
// a finished request whose response finds that register still full waits
// in its last step until the receiver takes the previous response.
// Configuration registers (image width, image height, pixel size in bytes)
// are to be written only while the block is idle; a width or height above
// the store size is taken as the store size, and stored pixels are never
// re-masked when the registers change.

module clipped_rectangle_fill import cfr_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    cfr_req_if.sink   req,
    cfr_rsp_if.source rsp,
    cfr_cfg_if.sink   cfg
);

    cfr_cmd_t    cmd;
    cfr_status_t status;

    // Configuration writes are always accepted; the registers live in the
    // datapath; pixel size is sampled when a request is loaded, width and height while it runs.
    assign cfg.ready = 1'b1;

    // The controller owns the request and response handshakes.
    cfr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // The datapath holds the request, the clipping result, the fill walk,
    // the frame store and the response payload.
    cfr_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .command        (req.command),
        .left           (req.left),
        .top            (req.top),
        .fill_width     (req.fill_width),
        .fill_height    (req.fill_height),
        .color          (req.color),
        .pixel_x        (req.pixel_x),
        .pixel_y        (req.pixel_y),
        .cfg_write      (cfg.valid && cfg.ready),
        .cfg_index      (cfg.index),
        .cfg_data       (cfg.data),
        .cmd            (cmd),
        .status         (status),
        .pixel_value    (rsp.pixel_value),
        .pixels_written (rsp.pixels_written),
        .out_of_range   (rsp.out_of_range)
    );

endmodule

/* tb/tb_clipped_rectangle_fill.sv */
// Self-checking testbench for the clipped rectangle fill framebuffer: directed and
// random fill and read requests across several image geometries and pixel sizes.
// Depends on cfr_pkg, the channel interfaces in cfr_if and the block itself.
`timescale 1ns / 1ps

module tb_clipped_rectangle_fill;
    import cfr_pkg::*;

    // The block clears its whole store after reset, and the largest fill keeps it
    // busy writing every pixel of the whole image. The limit on quiet cycles covers
    // either of those, plus the receiver hold-off, with a wide margin.
    localparam int QUIET_LIMIT     = 4 * (STORE_DEPTH + 4) + 1000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int SETTLE_CYCLES   = 16;
    localparam int IDLE_PERCENT    = 15;
    localparam int PICK_RANDOM     = -1;
    localparam int PHASES          = 10;

    // One fill or read request as it travels on the request channel.
    typedef struct packed {
        cmd_t               command;
        logic [COORD_W-1:0] left;
        logic [COORD_W-1:0] top;
        logic [COORD_W-1:0] fill_width;
        logic [COORD_W-1:0] fill_height;
        logic [COLOR_W-1:0] color;
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
    } fb_request_t;

    // One response: the pixel read, the pixel count of a fill and the range flag.
    typedef struct packed {
        logic [COLOR_W-1:0] pixel_value;
        logic [COUNT_W-1:0] pixels_written;
        logic               out_of_range;
    } fb_result_t;

    // Register settings for one phase of the random part. A field holding
    // PICK_RANDOM is drawn afresh when the phase starts.
    typedef struct {
        int width;
        int height;
        int bpp;
        int items;
        bit calm;
    } phase_plan_t;

    // Shadow framebuffer. It keeps its own copy of the pixels and registers, works
    // out the response of every accepted request, and compares the responses that
    // the block hands back against them in order.
    class frame_scoreboard;
        logic [COLOR_W-1:0] frame [STORE_DEPTH];
        logic [DIM_W-1:0]   width_reg;
        logic [DIM_W-1:0]   height_reg;
        logic [BPP_W-1:0]   bpp_reg;
        fb_result_t         results_due [$];
        int                 mismatches;

        function new();
            foreach (frame[i])
            begin
                frame[i] = '0;
            end
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            bpp_reg    = BPP_RESET;
            mismatches = 0;
        endfunction

        function void set_register(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_IMAGE_WIDTH:  width_reg  = data[DIM_W-1:0];
                REG_IMAGE_HEIGHT: height_reg = data[DIM_W-1:0];
                REG_PIXEL_BYTES:  bpp_reg    = data[BPP_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned active_width();
            int unsigned wv;
            wv = width_reg;
            return (wv > MAX_WIDTH) ? MAX_WIDTH : wv;
        endfunction

        function int unsigned active_height();
            int unsigned hv;
            hv = height_reg;
            return (hv > MAX_HEIGHT) ? MAX_HEIGHT : hv;
        endfunction

        // Low bytes of the colour that a fill keeps: zero bytes counts as one,
        // anything above four as four.
        function logic [COLOR_W-1:0] kept_colour_bits();
            int unsigned nbytes;
            int unsigned nbits;
            nbytes = bpp_reg;
            if (nbytes == 0)
            begin
                nbytes = 1;
            end
            if (nbytes > 4)
            begin
                nbytes = 4;
            end
            nbits = nbytes * 8;
            if (nbits > PIXEL_BITS)
            begin
                nbits = PIXEL_BITS;
            end
            return {COLOR_W{1'b1}} >> (COLOR_W - nbits);
        endfunction

        // Applies an accepted request to the shadow store and queues its response.
        function void note_request(fb_request_t r);
            fb_result_t         res;
            int unsigned        w;
            int unsigned        h;
            int unsigned        x0;
            int unsigned        y0;
            int unsigned        x1;
            int unsigned        y1;
            int unsigned        area;
            logic [COLOR_W-1:0] paint;
            w   = active_width();
            h   = active_height();
            res = '0;
            if (r.command == CMD_FILL)
            begin
                x0    = r.left;
                y0    = r.top;
                x1    = x0 + r.fill_width;
                y1    = y0 + r.fill_height;
                paint = r.color & kept_colour_bits();
                if (x0 <= w && y0 <= h)
                begin
                    if (x1 > w)
                    begin
                        x1 = w;
                    end
                    if (y1 > h)
                    begin
                        y1 = h;
                    end
                    if (x0 < x1 && y0 < y1)
                    begin
                        for (int unsigned y = y0; y < y1; y++)
                        begin
                            for (int unsigned x = x0; x < x1; x++)
                            begin
                                frame[y * w + x] = paint;
                            end
                        end
                        area = (x1 - x0) * (y1 - y0);
                        res.pixels_written = area[COUNT_W-1:0];
                    end
                end
            end
            else if (r.pixel_x >= w || r.pixel_y >= h)
            begin
                res.out_of_range = 1'b1;
            end
            else
            begin
                res.pixel_value = frame[r.pixel_y * w + r.pixel_x];
            end
            results_due.push_back(res);
        endfunction

        function void check_response(fb_result_t got);
            fb_result_t want;
            if (results_due.size() == 0)
            begin
                $display("%0t: unexpected response: pixel_value %h pixels_written %0d out_of_range %b",
                         $time, got.pixel_value, got.pixels_written, got.out_of_range);
                mismatches++;
                return;
            end
            want = results_due.pop_front();
            if (got.pixel_value !== want.pixel_value)
            begin
                $display("%0t: pixel_value expected %h actual %h",
                         $time, want.pixel_value, got.pixel_value);
                mismatches++;
            end
            if (got.pixels_written !== want.pixels_written)
            begin
                $display("%0t: pixels_written expected %0d actual %0d",
                         $time, want.pixels_written, got.pixels_written);
                mismatches++;
            end
            if (got.out_of_range !== want.out_of_range)
            begin
                $display("%0t: out_of_range expected %b actual %b",
                         $time, want.out_of_range, got.out_of_range);
                mismatches++;
            end
        endfunction

        function int pending();
            return results_due.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    // While set, neither side inserts random idle cycles of its own.
    bit steady = 1'b0;

    frame_scoreboard board = new();

    // The random part runs through these settings in turn. Full size, a single
    // pixel, oversized registers that must clamp, an empty width, an empty height,
    // odd strides and fresh random draws; the pixel size goes through zero, one,
    // four and above four.
    phase_plan_t plans [PHASES] = '{
        '{128, 128, 4, 120, 1'b1},
        '{1, 1, 1, 40, 1'b0},
        '{255, 200, 7, 110, 1'b0},
        '{0, 9, 0, 30, 1'b0},
        '{37, 5, 2, 90, 1'b0},
        '{PICK_RANDOM, PICK_RANDOM, PICK_RANDOM, 120, 1'b0},
        '{128, 0, 6, 30, 1'b0},
        '{128, 1, 3, 60, 1'b0},
        '{PICK_RANDOM, PICK_RANDOM, PICK_RANDOM, 120, 1'b0},
        '{128, 128, 1, 100, 1'b0}
    };

    cfr_req_if req_ch ();
    cfr_rsp_if rsp_ch ();
    cfr_cfg_if cfg_ch ();

    clipped_rectangle_fill u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source),
        .cfg   (cfg_ch.sink)
    );

    always #6 clk = ~clk;

    function automatic fb_request_t fill_request(int unsigned l, int unsigned t,
                                                 int unsigned fw, int unsigned fh,
                                                 logic [COLOR_W-1:0] col);
        fb_request_t r;
        r             = '0;
        r.command     = CMD_FILL;
        r.left        = COORD_W'(l);
        r.top         = COORD_W'(t);
        r.fill_width  = COORD_W'(fw);
        r.fill_height = COORD_W'(fh);
        r.color       = col;
        return r;
    endfunction

    function automatic fb_request_t read_request(int unsigned x, int unsigned y);
        fb_request_t r;
        r         = '0;
        r.command = CMD_READ;
        r.pixel_x = COORD_W'(x);
        r.pixel_y = COORD_W'(y);
        return r;
    endfunction

    // Random request for an image of w by h pixels. Every field starts fully
    // random, so the fields that a command ignores still toggle. Most reads land
    // in or just past the image; most fills are small rectangles placed on the
    // image, a few are huge ones that must be clamped, and the rest are noise
    // that nearly always clips away completely.
    function automatic fb_request_t random_request(int unsigned w, int unsigned h);
        fb_request_t r;
        int unsigned pick;
        r.command     = CMD_FILL;
        r.left        = COORD_W'($urandom);
        r.top         = COORD_W'($urandom);
        r.fill_width  = COORD_W'($urandom);
        r.fill_height = COORD_W'($urandom);
        r.color       = $urandom;
        r.pixel_x     = COORD_W'($urandom);
        r.pixel_y     = COORD_W'($urandom);
        pick          = $urandom_range(99);
        if (pick < 45)
        begin
            r.command = CMD_READ;
            if (pick >= 5)
            begin
                r.pixel_x = COORD_W'($urandom_range(w + 1));
                r.pixel_y = COORD_W'($urandom_range(h + 1));
            end
        end
        else if (pick >= 53)
        begin
            r.left        = COORD_W'($urandom_range(w));
            r.top         = COORD_W'($urandom_range(h));
            r.fill_width  = COORD_W'($urandom_range(20));
            r.fill_height = COORD_W'($urandom_range(12));
        end
        else if (pick >= 50)
        begin
            // Huge sizes from inside the image: the wide sums must not wrap.
            r.left = COORD_W'($urandom_range(w / 2));
            r.top  = COORD_W'($urandom_range(h / 2));
        end
        return r;
    endfunction

    // Offers one request, with occasional idle cycles in front of it, and holds
    // it until the block takes it. Valid is left high on return so that the next
    // request can follow without a gap; whoever stops sending lowers it.
    task automatic send_request(input fb_request_t r);
        while (!steady && $urandom_range(99) < IDLE_PERCENT)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.command     <= r.command;
        req_ch.left        <= r.left;
        req_ch.top         <= r.top;
        req_ch.fill_width  <= r.fill_width;
        req_ch.fill_height <= r.fill_height;
        req_ch.color       <= r.color;
        req_ch.pixel_x     <= r.pixel_x;
        req_ch.pixel_y     <= r.pixel_y;
        do
        begin
            @(posedge clk);
        end
        while (!req_ch.ready);
        board.note_request(r);
    endtask

    // Register write; valid stays high so that writes can go back to back, and the
    // caller lowers it after the last one.
    task automatic write_register(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ch.ready);
        board.set_register(idx, data);
    endtask

    // Stops offering requests, waits for every outstanding response and then lets
    // the clock run on so that the block is certainly idle.
    task automatic settle();
        req_ch.valid <= 1'b0;
        while (board.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Response side. It takes responses with random stalls and, twice during the
    // random part, holds off for a long stretch so that the output register fills
    // and the block has to stall its request channel.
    initial
    begin : response_sink
        fb_result_t seen;
        int         taken;
        int         hold_left;
        taken     = 0;
        hold_left = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                seen.pixel_value    = rsp_ch.pixel_value;
                seen.pixels_written = rsp_ch.pixels_written;
                seen.out_of_range   = rsp_ch.out_of_range;
                board.check_response(seen);
                taken++;
                if (taken == 250 || taken == 620)
                begin
                    hold_left = HOLD_OFF_CYCLES;
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
            end
        end
    end

    // Ends the run if no channel moves anything for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("status: fail");
        $finish;
    end

    initial
    begin : stimulus
        int w;
        int h;
        int bpp;
        rst_n              <= 1'b0;
        req_ch.valid       <= 1'b0;
        req_ch.command     <= CMD_FILL;
        req_ch.left        <= '0;
        req_ch.top         <= '0;
        req_ch.fill_width  <= '0;
        req_ch.fill_height <= '0;
        req_ch.color       <= '0;
        req_ch.pixel_x     <= '0;
        req_ch.pixel_y     <= '0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.index       <= REG_IMAGE_WIDTH;
        cfg_ch.data        <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset settings: 128 by 128 pixels, three bytes each.
        // The first requests wait out the clearing pass, and the reads show that
        // the store came up as zero, including the far corner.
        send_request(read_request(0, 0));
        send_request(read_request(127, 127));
        // Reads one past the image in each direction and at the very top of the
        // coordinate range.
        send_request(read_request(128, 0));
        send_request(read_request(0, 128));
        send_request(read_request(16'hFFFF, 16'hFFFF));
        // The whole image with an all-ones colour: the top byte is masked off.
        send_request(fill_request(0, 0, 128, 128, 32'hFFFF_FFFF));
        send_request(read_request(127, 127));
        // Origin exactly on the right or bottom edge passes the clip test but
        // leaves an empty span; one beyond it writes nothing at all.
        send_request(fill_request(128, 0, 5, 5, 32'h0000_1111));
        send_request(fill_request(0, 128, 5, 5, 32'h0000_2222));
        send_request(fill_request(129, 3, 4, 4, 32'h0000_3333));
        send_request(fill_request(3, 16'hFFFF, 4, 4, 32'h0000_4444));
        send_request(fill_request(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hA5A5_A5A5));
        // Zero width and zero height.
        send_request(fill_request(10, 20, 0, 7, 32'h0055_5555));
        send_request(fill_request(10, 20, 7, 0, 32'h0066_6666));
        // Near the corner with maximal sizes: the sums must not wrap, and the
        // rectangle is clamped to 8 by 3 pixels.
        send_request(fill_request(120, 125, 16'hFFFF, 16'hFFFF, 32'h1234_5678));
        send_request(read_request(127, 127));
        send_request(read_request(119, 125));
        // Single pixels in opposite corners, one of them painted back to zero.
        send_request(fill_request(127, 127, 1, 1, 32'hDEAD_BEEF));
        send_request(read_request(127, 127));
        send_request(fill_request(0, 0, 1, 1, 32'h0000_0000));
        send_request(read_request(0, 0));
        send_request(read_request(1, 0));

        // Random part, one phase per register setting. All three registers are
        // written in each phase, only once the block has gone idle.
        foreach (plans[p])
        begin
            settle();
            w   = (plans[p].width == PICK_RANDOM) ? $urandom_range(MAX_WIDTH, 1) : plans[p].width;
            h   = (plans[p].height == PICK_RANDOM) ? $urandom_range(MAX_HEIGHT, 1) : plans[p].height;
            bpp = (plans[p].bpp == PICK_RANDOM) ? $urandom_range(7) : plans[p].bpp;
            write_register(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
            write_register(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
            // The spare upper bits of the pixel size write carry noise.
            write_register(REG_PIXEL_BYTES,
                           {(CFG_DATA_W - BPP_W)'($urandom), BPP_W'(bpp)});
            cfg_ch.valid <= 1'b0;
            steady = plans[p].calm;
            repeat (plans[p].items)
            begin
                send_request(random_request(board.active_width(), board.active_height()));
            end
        end
        settle();

        if (board.pending() == 0 && board.mismatches == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
